FILE: rtl/dnns_pkg.sv
// ----------------------------------------------------------------------------
// dnns_pkg
// Shared types and constants for the descriptor nearest-neighbor search core.
// ----------------------------------------------------------------------------
package dnns_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int DIMS_DEF    = 128;
	localparam int LANES_DEF   = 4;
	localparam int TOP_MAX_DEF = 8;

	localparam int NUM_VALUES = 4;
	localparam int DIST_W     = 39;
	localparam int ACC_W      = 40;
	localparam logic [ACC_W-1:0] DIST_MAX = (ACC_W'(1) << DIST_W) - ACC_W'(1);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [5:0]        entry_index;
		logic [4:0]        chunk_index;
		logic signed [15:0] value_a;
		logic signed [15:0] value_b;
		logic signed [15:0] value_c;
		logic signed [15:0] value_d;
		logic              final_chunk;
	} item_t;

	typedef struct packed {
		logic [5:0]        match_index;
		logic [DIST_W-1:0] distance_sq;
		logic              found;
		logic              last_match;
	} result_t;

	typedef struct packed {
		logic wr_entry;
		logic wr_query;
		logic clear_list;
		logic issue;
		logic first;
		logic last;
		logic emit;
		logic emit_last;
		logic emit_empty;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cur_valid;
		logic pipe_busy;
	} ctrl_sts_t;

endpackage

FILE: rtl/descriptor_nearest_neighbor_search_core.sv
// ----------------------------------------------------------------------------
// descriptor_nearest_neighbor_search_core
// Nearest-neighbor search over a table of enrolled Q1.14 descriptors.
// ----------------------------------------------------------------------------
// A final query word starts a search: every valid entry is read one chunk of
// LANES elements a cycle from the per-lane descriptor banks, and an invalid
// entry is skipped. busy stays high through the scan, the pipeline drain and
// the emit of each reported match. Results come out one per cycle with
// result_strobe, each registered from its emit step, so the last one shows in
// the first cycle after busy falls. They must be taken as they come; the
// receiver cannot stall.
// The descriptor store has no reset; only the valid bits are cleared.
module descriptor_nearest_neighbor_search_core #(
	parameter int ENTRIES = dnns_pkg::ENTRIES_DEF,
	parameter int DIMS    = dnns_pkg::DIMS_DEF,
	parameter int LANES   = dnns_pkg::LANES_DEF,
	parameter int TOP_MAX = dnns_pkg::TOP_MAX_DEF,
	localparam int CHUNKS = (DIMS + LANES - 1) / LANES,
	localparam int EW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1,
	localparam int KW     = $clog2(TOP_MAX + 1),
	localparam int TW     = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dnns_pkg::item_t   item,
	output logic              result_strobe,
	output dnns_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        cfg_data
);
	import dnns_pkg::*;

	ctrl_cmd_t     cmd;
	ctrl_sts_t     sts;
	logic [KW-1:0] list_count;
	logic [EW-1:0] scan_entry;
	logic [CW-1:0] scan_chunk;
	logic [TW-1:0] emit_idx;

	assign cfg_ready = 1'b1;

	dnns_ctrl #(
		.ENTRIES(ENTRIES),
		.DIMS   (DIMS),
		.LANES  (LANES),
		.TOP_MAX(TOP_MAX)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.cmd       (cmd),
		.sts       (sts),
		.list_count(list_count),
		.scan_entry(scan_entry),
		.scan_chunk(scan_chunk),
		.emit_idx  (emit_idx)
	);

	dnns_datapath #(
		.ENTRIES(ENTRIES),
		.DIMS   (DIMS),
		.LANES  (LANES),
		.TOP_MAX(TOP_MAX)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.list_count   (list_count),
		.scan_entry   (scan_entry),
		.scan_chunk   (scan_chunk),
		.emit_idx     (emit_idx),
		.result_strobe(result_strobe),
		.result       (result)
	);

endmodule

FILE: rtl/dnns_ctrl.sv
// ----------------------------------------------------------------------------
// dnns_ctrl
// Sequencer: takes items, walks entries and chunks during a search, then
// steps through the ranked list to emit results.
// ----------------------------------------------------------------------------
module dnns_ctrl #(
	parameter int ENTRIES = dnns_pkg::ENTRIES_DEF,
	parameter int DIMS    = dnns_pkg::DIMS_DEF,
	parameter int LANES   = dnns_pkg::LANES_DEF,
	parameter int TOP_MAX = dnns_pkg::TOP_MAX_DEF,
	localparam int CHUNKS = (DIMS + LANES - 1) / LANES,
	localparam int EW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1,
	localparam int KW     = $clog2(TOP_MAX + 1),
	localparam int TW     = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  dnns_pkg::item_t     item,
	output logic                busy,
	output dnns_pkg::ctrl_cmd_t cmd,
	input  dnns_pkg::ctrl_sts_t sts,
	input  logic [KW-1:0]       list_count,
	output logic [EW-1:0]       scan_entry,
	output logic [CW-1:0]       scan_chunk,
	output logic [TW-1:0]       emit_idx
);
	import dnns_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam logic [EW-1:0] LAST_ENTRY = EW'(ENTRIES - 1);
	localparam logic [CW-1:0] LAST_CHUNK = CW'(CHUNKS - 1);

	logic [1:0]    state_q, state_d;
	logic [EW-1:0] entry_q, entry_d;
	logic [CW-1:0] chunk_q, chunk_d;
	logic [KW-1:0] rank_q, rank_d;
	logic          accept;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign scan_entry = entry_q;
	assign scan_chunk = chunk_q;
	assign emit_idx   = rank_q[TW-1:0];

	always_comb begin
		state_d = state_q;
		entry_d = entry_q;
		chunk_d = chunk_q;
		rank_d  = rank_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.opcode == OP_WRITE) begin
						cmd.wr_entry = 1'b1;
					end else begin
						cmd.wr_query = 1'b1;
						if (item.final_chunk) begin
							cmd.clear_list = 1'b1;
							entry_d = '0;
							chunk_d = '0;
							state_d = ST_SCAN;
						end
					end
				end
			end
			ST_SCAN: begin
				cmd.first = (chunk_q == '0);
				cmd.last  = (chunk_q == LAST_CHUNK);
				if (sts.cur_valid) begin
					cmd.issue = 1'b1;
				end
				// invalid entries are skipped without issuing any chunk
				if (!sts.cur_valid || chunk_q == LAST_CHUNK) begin
					chunk_d = '0;
					if (entry_q == LAST_ENTRY) begin
						state_d = ST_DRAIN;
					end else begin
						entry_d = entry_q + EW'(1);
					end
				end else begin
					chunk_d = chunk_q + CW'(1);
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					rank_d  = '0;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (list_count == '0) begin
					cmd.emit_empty = 1'b1;
					cmd.emit_last  = 1'b1;
					state_d = ST_IDLE;
				end else if (rank_q == list_count - KW'(1)) begin
					cmd.emit_last = 1'b1;
					state_d = ST_IDLE;
				end else begin
					rank_d = rank_q + KW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			entry_q <= '0;
			chunk_q <= '0;
			rank_q  <= '0;
		end else begin
			state_q <= state_d;
			entry_q <= entry_d;
			chunk_q <= chunk_d;
			rank_q  <= rank_d;
		end
	end

endmodule

FILE: rtl/dnns_datapath.sv
// ----------------------------------------------------------------------------
// dnns_datapath
// Descriptor and query stores, squared-distance pipeline, sorted best list
// and result register.
// ----------------------------------------------------------------------------
module dnns_datapath #(
	parameter int ENTRIES = dnns_pkg::ENTRIES_DEF,
	parameter int DIMS    = dnns_pkg::DIMS_DEF,
	parameter int LANES   = dnns_pkg::LANES_DEF,
	parameter int TOP_MAX = dnns_pkg::TOP_MAX_DEF,
	localparam int CHUNKS = (DIMS + LANES - 1) / LANES,
	localparam int EW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1,
	localparam int KW     = $clog2(TOP_MAX + 1),
	localparam int TW     = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dnns_pkg::item_t     item,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_data,
	input  dnns_pkg::ctrl_cmd_t cmd,
	output dnns_pkg::ctrl_sts_t sts,
	output logic [KW-1:0]       list_count,
	input  logic [EW-1:0]       scan_entry,
	input  logic [CW-1:0]       scan_chunk,
	input  logic [TW-1:0]       emit_idx,
	output logic                result_strobe,
	output dnns_pkg::result_t   result
);
	import dnns_pkg::*;

	localparam int DEPTH      = ENTRIES << CW;
	localparam int QDEPTH     = 1 << CW;
	localparam int LAST_LANES = DIMS - (CHUNKS - 1) * LANES;

	logic signed [15:0] vals [NUM_VALUES];
	logic [31:0]        entry32, chunk32;
	logic               entry_ok;
	logic [EW+CW-1:0]   wr_addr, rd_addr;
	logic [CW-1:0]      wr_chunk;
	logic [LANES-1:0]   lane_we;

	logic [ENTRIES-1:0] valid_q;
	logic [3:0]         top_k_q;
	logic [KW-1:0]      k_eff;

	logic signed [15:0] ent_s1 [LANES];
	logic signed [15:0] qry_s1 [LANES];
	logic               v_s1, first_s1, last_s1;
	logic [EW-1:0]      idx_s1;

	logic [ACC_W-1:0]   sq_s2 [LANES];
	logic               v_s2, first_s2, last_s2;
	logic [EW-1:0]      idx_s2;

	logic [ACC_W-1:0]   acc_q;
	logic               done_s3;
	logic [EW-1:0]      idx_s3;

	logic [ACC_W-1:0]   lane_sum, acc_sum;

	logic [DIST_W-1:0]  dist_q [TOP_MAX];
	logic [EW-1:0]      bidx_q [TOP_MAX];
	logic [KW-1:0]      cnt_q;
	logic [TOP_MAX-1:0] lt;

	assign vals[0] = item.value_a;
	assign vals[1] = item.value_b;
	assign vals[2] = item.value_c;
	assign vals[3] = item.value_d;

	assign entry32  = 32'(item.entry_index);
	assign chunk32  = 32'(item.chunk_index);
	assign entry_ok = entry32 < 32'(ENTRIES);
	assign wr_chunk = chunk32[CW-1:0];
	assign wr_addr  = {entry32[EW-1:0], wr_chunk};
	assign rd_addr  = {scan_entry, scan_chunk};

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			lane_we[j] = (j < NUM_VALUES) && (chunk32 * 32'(LANES) + 32'(j) < 32'(DIMS));
		end
	end

	// one store bank per lane so short chunks leave other lanes untouched
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		logic signed [15:0] ent_mem [DEPTH];
		logic signed [15:0] qry_mem [QDEPTH];
		logic signed [15:0] wdata;

		assign wdata = (g < NUM_VALUES) ? vals[g % NUM_VALUES] : 16'sd0;

		always_ff @(posedge clk) begin
			if (cmd.wr_entry && entry_ok && lane_we[g]) begin
				ent_mem[wr_addr] <= wdata;
			end
			if (cmd.wr_query && lane_we[g]) begin
				qry_mem[wr_chunk] <= wdata;
			end
			ent_s1[g] <= ent_mem[rd_addr];
			qry_s1[g] <= qry_mem[scan_chunk];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			top_k_q <= 4'd1;
		end else begin
			if (cmd.wr_entry && entry_ok) begin
				valid_q[entry32[EW-1:0]] <= 1'b1;
			end
			if (cfg_we) begin
				top_k_q <= cfg_data;
			end
		end
	end

	always_comb begin
		if (top_k_q == 4'd0) begin
			k_eff = KW'(1);
		end else if (32'(top_k_q) > 32'(TOP_MAX)) begin
			k_eff = KW'(TOP_MAX);
		end else begin
			k_eff = KW'(top_k_q);
		end
	end

	assign sts.cur_valid = valid_q[scan_entry];
	assign sts.pipe_busy = v_s1 || v_s2 || done_s3;
	assign list_count    = cnt_q;

	// squares: the last chunk may run past the vector end
	always_ff @(posedge clk) begin
		for (int j = 0; j < LANES; j++) begin
			logic signed [16:0] d;
			logic signed [33:0] p;
			d = 17'(ent_s1[j]) - 17'(qry_s1[j]);
			p = d * d;
			if (last_s1 && j >= LAST_LANES) begin
				sq_s2[j] <= '0;
			end else begin
				sq_s2[j] <= ACC_W'(p[32:0]);
			end
		end
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		idx_s2   <= idx_s1;
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		idx_s1   <= scan_entry;
		idx_s3   <= idx_s2;
	end

	always_comb begin
		lane_sum = '0;
		for (int j = 0; j < LANES; j++) begin
			lane_sum = lane_sum + sq_s2[j];
		end
		acc_sum = (first_s2 ? '0 : acc_q) + lane_sum;
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= (acc_sum > DIST_MAX) ? DIST_MAX : acc_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			v_s1    <= cmd.issue;
			v_s2    <= v_s1;
			done_s3 <= v_s2 && last_s2;
		end
	end

	// slots past the fill count act as infinitely far
	always_comb begin
		for (int i = 0; i < TOP_MAX; i++) begin
			lt[i] = (32'(i) >= 32'(cnt_q)) || (acc_q[DIST_W-1:0] < dist_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (done_s3) begin
			for (int i = 0; i < TOP_MAX; i++) begin
				if (32'(i) < 32'(k_eff)) begin
					if (i > 0 && lt[(i > 0) ? i - 1 : 0]) begin
						dist_q[i] <= dist_q[(i > 0) ? i - 1 : 0];
						bidx_q[i] <= bidx_q[(i > 0) ? i - 1 : 0];
					end else if (lt[i]) begin
						dist_q[i] <= acc_q[DIST_W-1:0];
						bidx_q[i] <= idx_s3;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clear_list) begin
			cnt_q <= '0;
		end else if (done_s3 && cnt_q < k_eff) begin
			cnt_q <= cnt_q + KW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (cmd.emit_empty) begin
				result.match_index <= '0;
				result.distance_sq <= '0;
				result.found       <= 1'b0;
			end else begin
				result.match_index <= 6'(32'(bidx_q[emit_idx]));
				result.distance_sq <= dist_q[emit_idx];
				result.found       <= 1'b1;
			end
			result.last_match <= cmd.emit_last;
		end
	end

endmodule
